// ===== rtl/ddm_pkg.sv =====
// Shared types and constants for the decimal digit multiplier.
package ddm_pkg;

  localparam int WORD_W     = 64;
  localparam int DIG_W      = 4;
  localparam int MAX_DIGITS = WORD_W / DIG_W;

  typedef logic [DIG_W-1:0] digit_t;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic load;
    logic step;
  } cell_ctl_t;

endpackage

// ===== rtl/ddm_in_if.sv =====
// Operand channel: two packed BCD numbers with valid/ready handshake.
interface ddm_in_if
  import ddm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] multiplicand_bcd;
  logic [WORD_W-1:0] multiplier_bcd;

  modport source (output valid, output multiplicand_bcd, output multiplier_bcd, input ready);
  modport sink   (input valid, input multiplicand_bcd, input multiplier_bcd, output ready);
endinterface

// ===== rtl/ddm_out_if.sv =====
// Result channel: packed BCD product and status flags with valid/ready handshake.
interface ddm_out_if
  import ddm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] product_bcd;
  logic              overflow;
  logic              bad_digit;

  modport source (output valid, output product_bcd, output overflow, output bad_digit,
                  input ready);
  modport sink   (input valid, input product_bcd, input overflow, input bad_digit,
                  output ready);
endinterface

// ===== rtl/decimal_digit_multiplier_unit.sv =====
// Decimal digit multiplier top level: a chain of DIGITS digit cells and its sequencer.
// The result word is registered once the last multiplier digit row has passed through the chain.
// One multiplier digit row per cycle while busy; the last row is held while the result is stalled.
// A new operand word is taken in the last cycle of the previous one.
// Reset is synchronous and clears the sequencer and the output valid flag only.
module decimal_digit_multiplier_unit
  import ddm_pkg::*;
#(
  parameter int DIGITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  ddm_in_if.sink    operands,
  ddm_out_if.source result
);

  localparam int DW    = DIGITS * DIG_W;
  localparam int CNT_W = $clog2(DIGITS);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DW-1:0]     b_sh;
  logic [DW-1:0]     prod_sh;
  logic              bad;
  logic              out_valid;
  logic [WORD_W-1:0] out_prod;
  logic              out_ovf;
  logic              out_bad;

  logic              accept;
  logic              last;
  logic              stall;
  logic              finish;
  logic              bad_in;
  logic              nonzero;
  logic [DW-1:0]     prod_next;
  cell_ctl_t         ctl;
  digit_t            r_dig [DIGITS];
  digit_t            q_dig [DIGITS];

  assign last   = (cnt == CNT_W'(DIGITS - 1));
  assign stall  = out_valid && !result.ready;
  assign finish = busy && last && !stall;
  assign operands.ready = !rst && (!busy || finish);
  assign accept = operands.valid && operands.ready;

  assign ctl.load = accept;
  assign ctl.step = busy && !(last && stall);

  always_comb begin
    bad_in = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      if (operands.multiplicand_bcd[i*DIG_W +: DIG_W] > 4'd9 ||
          operands.multiplier_bcd[i*DIG_W +: DIG_W] > 4'd9) begin
        bad_in = 1'b1;
      end
    end
  end

  generate
    for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      digit_t s_from_up;
      if (i == DIGITS - 1) begin : g_top
        assign s_from_up = '0;
      end else begin : g_mid
        assign s_from_up = r_dig[i+1];
      end
      ddm_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .a_new     (operands.multiplicand_bcd[i*DIG_W +: DIG_W]),
        .b_dig     (b_sh[DIG_W-1:0]),
        .s_up      (s_from_up),
        .sum_dig   (r_dig[i]),
        .carry_dig (q_dig[i])
      );
    end
  endgenerate

  // After the last row the chain holds the dropped high part of the product.
  always_comb begin
    nonzero = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      if (q_dig[i] != '0) nonzero = 1'b1;
      if (i > 0 && r_dig[i] != '0) nonzero = 1'b1;
    end
  end

  assign prod_next = {r_dig[0], prod_sh[DW-1:DIG_W]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (ctl.step) begin
        if (last) begin
          busy <= 1'b0;
          cnt  <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_sh    <= operands.multiplier_bcd[DW-1:0];
      prod_sh <= '0;
      bad     <= bad_in;
    end else if (ctl.step) begin
      b_sh    <= {{DIG_W{1'b0}}, b_sh[DW-1:DIG_W]};
      prod_sh <= prod_next;
    end
    if (finish) begin
      out_prod <= bad ? '0 : WORD_W'(prod_next);
      out_ovf  <= bad ? 1'b0 : nonzero;
      out_bad  <= bad;
    end
  end

  assign result.valid       = out_valid;
  assign result.product_bcd = out_prod;
  assign result.overflow    = out_ovf;
  assign result.bad_digit   = out_bad;

`ifndef SYNTHESIS
  a_idle_count_zero: assert property (@(posedge clk) disable iff (rst)
    !busy |-> cnt == '0)
    else $error("digit counter not at zero while idle");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && cnt == '0)
    else $error("accepted word did not start the digit sequence");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    finish |=> result.valid)
    else $error("finished word not presented on the result channel");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.bad_digit |-> result.product_bcd == '0 && !result.overflow)
    else $error("bad digit result carries a product or overflow");
`endif

endmodule

// ===== rtl/ddm_cell.sv =====
// One digit cell: holds a multiplicand digit, a partial sum digit and a carry digit.
module ddm_cell
  import ddm_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  digit_t    a_new,
  input  digit_t    b_dig,
  input  digit_t    s_up,
  output digit_t    sum_dig,
  output digit_t    carry_dig
);

  localparam logic [15:0] RECIP_10 = 16'd205;
  localparam int          RECIP_SH = 11;

  digit_t      a;
  digit_t      s;
  digit_t      c;
  logic [7:0]  pp;
  logic [7:0]  sum;
  logic [15:0] scaled;
  logic [7:0]  q10;
  logic [7:0]  rem8;

  // For decimal digits the sum stays below 100, so the carry out is at most 9.
  assign pp        = {4'b0, a} * {4'b0, b_dig};
  assign sum       = pp + {4'b0, s} + {4'b0, c};
  assign scaled    = {8'b0, sum} * RECIP_10;
  assign carry_dig = scaled[RECIP_SH+DIG_W-1:RECIP_SH];
  assign q10       = {4'b0, carry_dig} * 8'd10;
  assign rem8      = sum - q10;
  assign sum_dig   = rem8[DIG_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a <= a_new;
      s <= '0;
      c <= '0;
    end else if (ctl.step) begin
      // The sum digit moves one place down; the carry stays at this weight.
      s <= s_up;
      c <= carry_dig;
    end
  end

endmodule
